// ----- design/ilst_pkg.sv -----
// Shared types and constants for the indexed list block.
// No dependencies; used by ilst_cell, ilst_ctrl, indexed_list_insert_remove and its testbench.
package ilst_pkg;

  localparam int DEPTH_DEF       = 16;
  localparam int VALUE_WIDTH_DEF = 32;

  localparam int MODE_W   = 3;
  localparam int STATUS_W = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_APPEND = 3'd0,
    MODE_INSERT = 3'd1,
    MODE_REMOVE = 3'd2,
    MODE_TRIM   = 3'd3,
    MODE_DUMP   = 3'd4
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // per-cell action for one cycle
  typedef enum logic [1:0] {
    OP_HOLD  = 2'd0,
    OP_LOAD  = 2'd1,
    OP_LEFT  = 2'd2,
    OP_RIGHT = 2'd3
  } cell_op_t;

endpackage

// ----- design/indexed_list_insert_remove.sv -----
// Indexed list top level: ilst_ctrl plus a row of DEPTH ilst_cell entries.
// Result word on out_valid in the cycle after start is taken.
// Append, insert, remove and trim give one word each; a dump of n entries
// emits n words back to back (busy high until the last is produced), set by the
// rotation of the cell row by one place per cycle. Receiver cannot stall.
// Reset (rst_n, synchronous) empties the list; stored entries are not cleared.
module indexed_list_insert_remove #(
  parameter int DEPTH       = ilst_pkg::DEPTH_DEF,
  parameter int VALUE_WIDTH = ilst_pkg::VALUE_WIDTH_DEF,
  localparam int CW         = $clog2(DEPTH + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [ilst_pkg::MODE_W-1:0]   in_mode,
  input  logic [CW-1:0]                 in_index,
  input  logic [CW-1:0]                 in_count,
  input  logic [VALUE_WIDTH-1:0]        in_value,
  output logic                          out_valid,
  output logic [ilst_pkg::STATUS_W-1:0] out_status,
  output logic [CW-1:0]                 out_size_now,
  output logic [VALUE_WIDTH-1:0]        out_entry_value,
  output logic                          out_entry_valid,
  output logic                          out_last
);
  import ilst_pkg::*;

  cell_op_t               cell_op [DEPTH];
  logic [VALUE_WIDTH-1:0] load_d;
  logic [VALUE_WIDTH-1:0] cell_q  [DEPTH];

  ilst_ctrl #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_mode         (in_mode),
    .in_index        (in_index),
    .in_count        (in_count),
    .in_value        (in_value),
    .head_d          (cell_q[0]),
    .cell_op         (cell_op),
    .load_d          (load_d),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_size_now    (out_size_now),
    .out_entry_value (out_entry_value),
    .out_entry_valid (out_entry_valid),
    .out_last        (out_last)
  );

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [VALUE_WIDTH-1:0] left_d;
    logic [VALUE_WIDTH-1:0] right_d;

    if (g == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_mid_l
      assign left_d = cell_q[g-1];
    end

    if (g == DEPTH - 1) begin : g_final
      assign right_d = '0;
    end else begin : g_mid_r
      assign right_d = cell_q[g+1];
    end

    ilst_cell #(
      .VALUE_WIDTH (VALUE_WIDTH)
    ) u_cell (
      .clk     (clk),
      .op      (cell_op[g]),
      .load_d  (load_d),
      .left_d  (left_d),
      .right_d (right_d),
      .q       (cell_q[g])
    );
  end

endmodule

// ----- design/ilst_cell.sv -----
// One storage cell of the list row: holds a single entry and takes a new
// one from the load bus or from either neighbor. Depends on ilst_pkg.
module ilst_cell #(
  parameter int VALUE_WIDTH = ilst_pkg::VALUE_WIDTH_DEF
) (
  input  logic                   clk,
  input  ilst_pkg::cell_op_t     op,
  input  logic [VALUE_WIDTH-1:0] load_d,
  input  logic [VALUE_WIDTH-1:0] left_d,
  input  logic [VALUE_WIDTH-1:0] right_d,
  output logic [VALUE_WIDTH-1:0] q
);
  import ilst_pkg::*;

  logic [VALUE_WIDTH-1:0] data_r;
  logic [VALUE_WIDTH-1:0] data_nxt;

  always_comb begin
    case (op)
      OP_HOLD:  data_nxt = data_r;
      OP_LOAD:  data_nxt = load_d;
      OP_LEFT:  data_nxt = left_d;
      OP_RIGHT: data_nxt = right_d;
      default:  data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign q = data_r;

endmodule

// ----- design/ilst_ctrl.sv -----
// Controller for the indexed list: range checks, entry count, dump sequencing,
// per-cell shift commands and registered result word. Depends on ilst_pkg.
module ilst_ctrl #(
  parameter int DEPTH       = ilst_pkg::DEPTH_DEF,
  parameter int VALUE_WIDTH = ilst_pkg::VALUE_WIDTH_DEF,
  localparam int CW         = $clog2(DEPTH + 1)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [ilst_pkg::MODE_W-1:0]  in_mode,
  input  logic [CW-1:0]                in_index,
  input  logic [CW-1:0]                in_count,
  input  logic [VALUE_WIDTH-1:0]       in_value,
  input  logic [VALUE_WIDTH-1:0]       head_d,
  output ilst_pkg::cell_op_t           cell_op [DEPTH],
  output logic [VALUE_WIDTH-1:0]       load_d,
  output logic                         out_valid,
  output logic [ilst_pkg::STATUS_W-1:0] out_status,
  output logic [CW-1:0]                out_size_now,
  output logic [VALUE_WIDTH-1:0]       out_entry_value,
  output logic                         out_entry_valid,
  output logic                         out_last
);
  import ilst_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_DUMP
  } state_t;

  typedef enum logic [1:0] {
    SH_NONE,
    SH_INS,
    SH_DEL,
    SH_ROT
  } shift_t;

  state_t         state_r, state_nxt;
  logic [CW-1:0]  held_r, held_nxt;
  logic [CW-1:0]  dcnt_r, dcnt_nxt;
  logic           valid_r, valid_nxt;
  status_t        status_r, status_nxt;
  logic [CW-1:0]  size_r, size_nxt;
  logic [VALUE_WIDTH-1:0] value_r, value_nxt;
  logic           evalid_r, evalid_nxt;
  logic           last_r, last_nxt;

  shift_t         shift;
  logic [CW-1:0]  pos;
  logic           accept;
  logic           full;

  assign busy   = (state_r == S_DUMP);
  assign accept = start && !busy;
  assign full   = (held_r == CW'(DEPTH));

  always_comb begin
    state_nxt  = state_r;
    held_nxt   = held_r;
    dcnt_nxt   = dcnt_r;
    valid_nxt  = 1'b0;
    status_nxt = ST_OK;
    size_nxt   = held_r;
    value_nxt  = '0;
    evalid_nxt = 1'b0;
    last_nxt   = 1'b1;
    shift      = SH_NONE;
    pos        = held_r;

    if (state_r == S_DUMP) begin
      // rotate the held part of the row: head goes out and back in at the tail
      valid_nxt  = 1'b1;
      value_nxt  = head_d;
      evalid_nxt = 1'b1;
      shift      = SH_ROT;
      dcnt_nxt   = dcnt_r + 1'b1;
      last_nxt   = ((dcnt_r + 1'b1) == held_r);
      if ((dcnt_r + 1'b1) == held_r) begin
        state_nxt = S_IDLE;
      end
    end else if (accept) begin
      valid_nxt = 1'b1;
      case (in_mode)
        MODE_APPEND: begin
          if (full) begin
            status_nxt = ST_FULL;
          end else begin
            shift    = SH_INS;
            pos      = held_r;
            held_nxt = held_r + 1'b1;
          end
        end
        MODE_INSERT: begin
          if (in_index > held_r) begin
            status_nxt = ST_RANGE;
          end else if (full) begin
            status_nxt = ST_FULL;
          end else begin
            shift    = SH_INS;
            pos      = in_index;
            held_nxt = held_r + 1'b1;
          end
        end
        MODE_REMOVE: begin
          if (in_index >= held_r) begin
            status_nxt = ST_RANGE;
          end else begin
            shift    = SH_DEL;
            pos      = in_index;
            held_nxt = held_r - 1'b1;
          end
        end
        MODE_TRIM: begin
          if (in_count > held_r) begin
            status_nxt = ST_RANGE;
          end else begin
            held_nxt = held_r - in_count;
          end
        end
        MODE_DUMP: begin
          if (held_r != '0) begin
            value_nxt  = head_d;
            evalid_nxt = 1'b1;
            shift      = SH_ROT;
            dcnt_nxt   = CW'(1);
            last_nxt   = (held_r == CW'(1));
            if (held_r != CW'(1)) begin
              state_nxt = S_DUMP;
            end
          end
        end
        default: begin
          status_nxt = ST_RANGE;
        end
      endcase
      size_nxt = held_nxt;
    end
  end

  assign load_d = (shift == SH_ROT) ? head_d : in_value;

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      cell_op[i] = OP_HOLD;
      case (shift)
        SH_INS: begin
          if (CW'(i) == pos) begin
            cell_op[i] = OP_LOAD;
          end else if (CW'(i) > pos && CW'(i) <= held_r) begin
            cell_op[i] = OP_LEFT;
          end
        end
        SH_DEL: begin
          if (CW'(i) >= pos && CW'(i + 1) < held_r) begin
            cell_op[i] = OP_RIGHT;
          end
        end
        SH_ROT: begin
          if (CW'(i + 1) < held_r) begin
            cell_op[i] = OP_RIGHT;
          end else if (CW'(i + 1) == held_r) begin
            cell_op[i] = OP_LOAD;
          end
        end
        default: cell_op[i] = OP_HOLD;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      held_r  <= '0;
      dcnt_r  <= '0;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      held_r  <= held_nxt;
      dcnt_r  <= dcnt_nxt;
      valid_r <= valid_nxt;
    end
    status_r <= status_nxt;
    size_r   <= size_nxt;
    value_r  <= value_nxt;
    evalid_r <= evalid_nxt;
    last_r   <= last_nxt;
  end

  assign out_valid       = valid_r;
  assign out_status      = status_r;
  assign out_size_now    = size_r;
  assign out_entry_value = value_r;
  assign out_entry_valid = evalid_r;
  assign out_last        = last_r;

endmodule

// ----- dv/indexed_list_insert_remove_tb.sv -----
// Self-checking testbench for indexed_list_insert_remove: directed table, then random ops.
// Every accepted op runs through an in-bench list predictor; every result word is checked.
// Depends on ilst_pkg (mode and status codes) and the indexed_list_insert_remove RTL.
module indexed_list_insert_remove_tb;
  import ilst_pkg::*;

  localparam int DEPTH    = DEPTH_DEF;
  localparam int VALUE_W  = VALUE_WIDTH_DEF;
  localparam int SIZE_W   = $clog2(DEPTH + 1);
  localparam int NUM_ROWS = 22;
  localparam int RANDOM_ITEMS = 220;
  localparam logic [MODE_W-1:0] MODE_UNUSED_LO = 3'd5;
  localparam logic [MODE_W-1:0] MODE_UNUSED_HI = 3'd7;

  typedef struct {
    status_t              status;
    logic [SIZE_W-1:0]    size;
    logic [VALUE_W-1:0]   value;
    logic                 valid;
    logic                 last;
  } word_t;

  typedef struct {
    logic [MODE_W-1:0]    mode;
    logic [SIZE_W-1:0]    idx;
    logic [SIZE_W-1:0]    cnt;
    logic [VALUE_W-1:0]   val;
    bit                   typed;
    status_t              st;
    int                   sz;
  } script_row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic [MODE_W-1:0]    in_mode;
  logic [SIZE_W-1:0]    in_index;
  logic [SIZE_W-1:0]    in_count;
  logic [VALUE_W-1:0]   in_value;
  logic                 out_valid;
  logic [STATUS_W-1:0]  out_status;
  logic [SIZE_W-1:0]    out_size_now;
  logic [VALUE_W-1:0]   out_entry_value;
  logic                 out_entry_valid;
  logic                 out_last;

  // predicted list contents
  logic [VALUE_W-1:0]   list_mem [DEPTH];
  int                   list_len;
  word_t                expected_words [$];
  int                   mismatches;
  int                   items_sent;
  script_row_t          script [NUM_ROWS];

  indexed_list_insert_remove uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_mode         (in_mode),
    .in_index        (in_index),
    .in_count        (in_count),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_size_now    (out_size_now),
    .out_entry_value (out_entry_value),
    .out_entry_valid (out_entry_valid),
    .out_last        (out_last)
  );

  always #5 clk = ~clk;

  initial begin
    #1000000;
    $display("FAIL indexed_list_insert_remove");
    $finish;
  end

  task automatic push_word(input status_t st, input int sz,
                           input logic [VALUE_W-1:0] v,
                           input logic vld, input logic lst);
    word_t w;
    w.status = st;
    w.size   = SIZE_W'(sz);
    w.value  = v;
    w.valid  = vld;
    w.last   = lst;
    expected_words.push_back(w);
  endtask

  // list behavior for one accepted op; queues the result words it causes
  task automatic apply_list_op(input logic [MODE_W-1:0] mode,
                               input logic [SIZE_W-1:0] idx,
                               input logic [SIZE_W-1:0] cnt,
                               input logic [VALUE_W-1:0] val);
    status_t st;
    int j;
    st = ST_OK;
    case (mode)
      MODE_APPEND: begin
        if (list_len >= DEPTH) st = ST_FULL;
        else begin
          list_mem[list_len] = val;
          list_len++;
        end
      end
      MODE_INSERT: begin
        if (idx > list_len) st = ST_RANGE;
        else if (list_len >= DEPTH) st = ST_FULL;
        else begin
          for (j = list_len; j > idx; j--) list_mem[j] = list_mem[j-1];
          list_mem[idx] = val;
          list_len++;
        end
      end
      MODE_REMOVE: begin
        if (idx >= list_len) st = ST_RANGE;
        else begin
          for (j = idx; j + 1 < list_len; j++) list_mem[j] = list_mem[j+1];
          list_len--;
        end
      end
      MODE_TRIM: begin
        if (cnt > list_len) st = ST_RANGE;
        else list_len -= cnt;
      end
      MODE_DUMP: ;
      default: st = ST_RANGE;
    endcase
    if (mode == MODE_DUMP && list_len != 0) begin
      for (j = 0; j < list_len; j++)
        push_word(ST_OK, list_len, list_mem[j], 1'b1, j + 1 == list_len);
    end else begin
      push_word(st, list_len, '0, 1'b0, 1'b1);
    end
  endtask

  // random gaps, none in the quiet stretch
  task automatic maybe_idle();
    if (!(items_sent >= 120 && items_sent < 180) && $urandom_range(0, 99) < 30) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic issue_op(input logic [MODE_W-1:0] mode, input logic [SIZE_W-1:0] idx,
                          input logic [SIZE_W-1:0] cnt, input logic [VALUE_W-1:0] val);
    maybe_idle();
    start    <= 1'b1;
    in_mode  <= mode;
    in_index <= idx;
    in_count <= cnt;
    in_value <= val;
    @(posedge clk);
    while (busy) @(posedge clk);
    apply_list_op(mode, idx, cnt, val);
    items_sent++;
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
  endtask

  function automatic logic [VALUE_W-1:0] rand_value();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return VALUE_W'($urandom());
  endfunction

  // adds until full, a few refused adds, then a dump
  task automatic fill_burst();
    int extra;
    while (list_len < DEPTH) begin
      if ($urandom_range(0, 1)) issue_op(MODE_APPEND, SIZE_W'($urandom_range(0, 31)), '0,
                                         rand_value());
      else issue_op(MODE_INSERT, SIZE_W'($urandom_range(0, list_len)), '0, rand_value());
    end
    extra = $urandom_range(1, 3);
    repeat (extra) begin
      case ($urandom_range(0, 2))
        0: issue_op(MODE_APPEND, '0, '0, rand_value());
        1: issue_op(MODE_INSERT, SIZE_W'($urandom_range(0, list_len)), '0, rand_value());
        default: issue_op(MODE_INSERT, SIZE_W'($urandom_range(list_len + 1, 31)), '0,
                          rand_value());
      endcase
    end
    issue_op(MODE_DUMP, '0, '0, rand_value());
  endtask

  task automatic drain_some();
    repeat ($urandom_range(2, 6)) begin
      if (list_len == 0) issue_op(MODE_TRIM, '0, '0, rand_value());
      else if ($urandom_range(0, 2) != 0)
        issue_op(MODE_REMOVE, SIZE_W'($urandom_range(0, list_len - 1)), '0, rand_value());
      else
        issue_op(MODE_TRIM, '0, SIZE_W'($urandom_range(0, list_len)), rand_value());
    end
  endtask

  task automatic mixed_ops();
    logic [MODE_W-1:0] m;
    repeat ($urandom_range(4, 10)) begin
      m = MODE_W'($urandom_range(0, 4));
      issue_op(m, SIZE_W'($urandom_range(0, list_len)),
               SIZE_W'($urandom_range(0, list_len + 1)), rand_value());
    end
  endtask

  task automatic noise_ops();
    repeat ($urandom_range(1, 4))
      issue_op(MODE_W'($urandom_range(0, 7)), SIZE_W'($urandom_range(0, 31)),
               SIZE_W'($urandom_range(0, 31)), VALUE_W'($urandom()));
  endtask

  task automatic note_mismatch(input string what, input word_t want);
    mismatches++;
    if (mismatches <= 10)
      $display({"%0t mismatch (%s): exp st=%0d sz=%0d val=%h v=%b l=%b,",
                " got st=%0d sz=%0d val=%h v=%b l=%b"},
               $time, what, want.status, want.size, want.value, want.valid, want.last,
               out_status, out_size_now, out_entry_value, out_entry_valid, out_last);
  endtask

  always @(posedge clk) begin : check_words
    word_t want;
    if (rst_n && out_valid) begin
      if (expected_words.size() == 0) begin
        want = '{ST_OK, '0, '0, 1'b0, 1'b0};
        note_mismatch("no word expected", want);
      end else begin
        want = expected_words.pop_front();
        if (out_status !== want.status || out_size_now !== want.size ||
            out_entry_value !== want.value || out_entry_valid !== want.valid ||
            out_last !== want.last)
          note_mismatch("field", want);
      end
    end
  end

  initial begin
    bit drained_once;
    clk      = 1'b0;
    rst_n    = 1'b0;
    start    = 1'b0;
    in_mode  = MODE_APPEND;
    in_index = '0;
    in_count = '0;
    in_value = '0;
    list_len = 0;
    mismatches = 0;
    items_sent = 0;
    drained_once = 0;
    foreach (list_mem[k]) list_mem[k] = '0;

    // mode, index, count, value, typed, status, size
    script = '{
      '{MODE_DUMP,      5'd0,  5'd0,  32'h0000_0000, 1'b1, ST_OK,    0},
      '{MODE_REMOVE,    5'd0,  5'd0,  32'h0000_0000, 1'b1, ST_RANGE, 0},
      '{MODE_TRIM,      5'd0,  5'd1,  32'h0000_0000, 1'b1, ST_RANGE, 0},
      '{MODE_TRIM,      5'd0,  5'd0,  32'h0000_0000, 1'b1, ST_OK,    0},
      '{MODE_INSERT,    5'd1,  5'd0,  32'h1234_5678, 1'b1, ST_RANGE, 0},
      '{MODE_INSERT,    5'd0,  5'd0,  32'hFFFF_FFFF, 1'b1, ST_OK,    1},
      '{MODE_APPEND,    5'd31, 5'd31, 32'h0000_0000, 1'b1, ST_OK,    2},
      '{MODE_INSERT,    5'd2,  5'd0,  32'hA5A5_A5A5, 1'b1, ST_OK,    3},
      '{MODE_INSERT,    5'd1,  5'd0,  32'h5A5A_5A5A, 1'b1, ST_OK,    4},
      '{MODE_DUMP,      5'd0,  5'd0,  32'h0000_0000, 1'b0, ST_OK,    0},
      '{MODE_REMOVE,    5'd4,  5'd0,  32'h0000_0000, 1'b1, ST_RANGE, 4},
      '{MODE_REMOVE,    5'd31, 5'd0,  32'h0000_0000, 1'b1, ST_RANGE, 4},
      '{MODE_INSERT,    5'd16, 5'd0,  32'hDEAD_BEEF, 1'b1, ST_RANGE, 4},
      '{MODE_REMOVE,    5'd1,  5'd0,  32'h0000_0000, 1'b1, ST_OK,    3},
      '{MODE_UNUSED_LO, 5'd0,  5'd0,  32'hFFFF_FFFF, 1'b1, ST_RANGE, 3},
      '{MODE_UNUSED_HI, 5'd31, 5'd31, 32'h0000_0000, 1'b1, ST_RANGE, 3},
      '{MODE_TRIM,      5'd0,  5'd4,  32'h0000_0000, 1'b1, ST_RANGE, 3},
      '{MODE_DUMP,      5'd0,  5'd0,  32'h0000_0000, 1'b0, ST_OK,    0},
      '{MODE_TRIM,      5'd0,  5'd3,  32'h0000_0000, 1'b1, ST_OK,    0},
      '{MODE_TRIM,      5'd0,  5'd16, 32'h0000_0000, 1'b1, ST_RANGE, 0},
      '{MODE_APPEND,    5'd0,  5'd0,  32'h8000_0001, 1'b1, ST_OK,    1},
      '{MODE_DUMP,      5'd0,  5'd0,  32'h0000_0000, 1'b0, ST_OK,    0}
    };

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (script[i]) begin
      issue_op(script[i].mode, script[i].idx, script[i].cnt, script[i].val);
      // typed rows carry a single word, the newest one queued
      if (script[i].typed && (expected_words[$].status !== script[i].st ||
                              expected_words[$].size !== SIZE_W'(script[i].sz))) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t mismatch (table row %0d): exp st=%0d sz=%0d, got st=%0d sz=%0d",
                   $time, i, script[i].st, script[i].sz,
                   expected_words[$].status, expected_words[$].size);
      end
    end

    while (items_sent < NUM_ROWS + RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1, 2: fill_burst();
        3, 4:    drain_some();
        5, 6, 7: mixed_ops();
        8:       noise_ops();
        default: issue_op(MODE_DUMP, '0, '0, rand_value());
      endcase
      if (!drained_once && items_sent >= 200) begin
        drained_once = 1;
        wait_drained();
      end
    end

    wait_drained();
    repeat (DEPTH + 4) @(posedge clk);
    if (mismatches == 0)
      $display("PASS indexed_list_insert_remove");
    else
      $display("FAIL indexed_list_insert_remove");
    $finish;
  end

endmodule
